>>> rtl/core/mtep_pkg.sv
// Shared types and constants for the MIDI track event parser.
package mtep_pkg;

    typedef enum logic [2:0] {
        PH_DELTA,
        PH_STATUS,
        PH_DATA1,
        PH_DATA2,
        PH_MTYPE,
        PH_LEN,
        PH_SKIP,
        PH_PAYLOAD
    } mtep_phase_t;

    typedef enum logic [2:0] {
        KIND_NOTE  = 3'd0,
        KIND_TEMPO = 3'd1,
        KIND_TSIG  = 3'd2,
        KIND_EOT   = 3'd3,
        KIND_ERROR = 3'd4
    } mtep_kind_t;

    typedef enum logic [1:0] {
        ERR_DELTA_VLQ = 2'd0,
        ERR_META_LEN  = 2'd1,
        ERR_STATUS    = 2'd2,
        ERR_LEN_VLQ   = 2'd3
    } mtep_err_t;

    localparam logic [7:0] ST_SYSEX      = 8'hF0;
    localparam logic [7:0] ST_SYSEX_ESC  = 8'hF7;
    localparam logic [7:0] ST_META       = 8'hFF;
    localparam logic [7:0] META_EOT      = 8'h2F;
    localparam logic [7:0] META_TEMPO    = 8'h51;
    localparam logic [7:0] META_TSIG     = 8'h58;
    localparam logic [27:0] LEN_TEMPO    = 28'h3;
    localparam logic [27:0] LEN_TSIG     = 28'h4;
    localparam logic [3:0] HI_NOTE_OFF   = 4'h8;
    localparam logic [3:0] HI_NOTE_ON    = 4'h9;
    localparam logic [3:0] HI_PROG       = 4'hC;
    localparam logic [3:0] HI_PRESS      = 4'hD;
    localparam logic [3:0] HI_SYSTEM     = 4'hF;

    // note table epoch tag width
    localparam int EPOCH_W = 8;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_active;
        logic new_track;
    } mtep_tbl_req_t;

    typedef struct packed {
        mtep_kind_t  kind;
        logic [3:0]  channel;
        logic [6:0]  key;
        logic [31:0] start_tick;
        logic [31:0] event_tick;
        logic [23:0] tempo_value;
        logic [7:0]  sig_numerator;
        logic [7:0]  sig_denominator_exp;
        mtep_err_t   error_code;
    } mtep_result_t;

endpackage

>>> rtl/core/mtep_if.sv
// Valid/ready channel interfaces for track bytes and parsed events.
interface mtep_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       track_start;

    modport source (output valid, output data_byte, output track_start, input ready);
    modport sink (input valid, input data_byte, input track_start, output ready);
endinterface

interface mtep_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [3:0]  channel;
    logic [6:0]  key;
    logic [31:0] start_tick;
    logic [31:0] event_tick;
    logic [23:0] tempo_value;
    logic [7:0]  sig_numerator;
    logic [7:0]  sig_denominator_exp;
    logic [1:0]  error_code;

    modport source (output valid, output kind, output channel, output key,
                    output start_tick, output event_tick, output tempo_value,
                    output sig_numerator, output sig_denominator_exp,
                    output error_code, input ready);
    modport sink (input valid, input kind, input channel, input key,
                  input start_tick, input event_tick, input tempo_value,
                  input sig_numerator, input sig_denominator_exp,
                  input error_code, output ready);
endinterface

>>> rtl/core/mtep_note_table.sv
// Per channel/key note table: active flag and start tick, epoch tagged.
module mtep_note_table #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mtep_pkg::mtep_tbl_req_t req,
    input  logic [AW-1:0]          addr,
    input  logic [31:0]            wr_start,
    output logic                   rd_active,
    output logic [31:0]            rd_start,
    output logic                   busy
);

    localparam int EW = mtep_pkg::EPOCH_W;
    localparam int MW = EW + 1 + 32;

    logic [MW-1:0]   mem [DEPTH];
    logic [MW-1:0]   rd_data_reg;
    logic [EW-1:0]   epoch_reg;
    logic            sweep_reg;
    logic [AW-1:0]   sweep_idx_reg;

    assign busy      = sweep_reg;
    assign rd_start  = rd_data_reg[31:0];
    assign rd_active = rd_data_reg[32] && (rd_data_reg[MW-1:33] == epoch_reg);

    // control: epoch advances per track; after reset and on wrap, a sweep clears every entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg     <= '0;
            sweep_reg     <= 1'b1;
            sweep_idx_reg <= '0;
        end
        else
        begin
            if (sweep_reg)
            begin
                if (sweep_idx_reg == AW'(DEPTH - 1))
                begin
                    sweep_reg <= 1'b0;
                end
                sweep_idx_reg <= sweep_idx_reg + 1'b1;
            end
            else if (req.new_track)
            begin
                if (epoch_reg == {EW{1'b1}})
                begin
                    epoch_reg     <= '0;
                    sweep_reg     <= 1'b1;
                    sweep_idx_reg <= '0;
                end
                else
                begin
                    epoch_reg <= epoch_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sweep_reg)
        begin
            mem[sweep_idx_reg] <= '0;
        end
        else if (req.wr_en)
        begin
            mem[addr] <= {epoch_reg, req.wr_active, wr_start};
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

endmodule

>>> rtl/core/mtep_parser.sv
// Byte-level track parser with result register.
module mtep_parser #(
    parameter int CHANNELS   = 16,
    parameter int KEYS       = 128,
    parameter int TICK_WIDTH = 32,
    parameter int AW         = 11
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    acc,
    input  logic [7:0]              data_byte,
    input  logic                    track_start,
    input  logic                    out_ready,
    input  logic                    tbl_active,
    input  logic [31:0]             tbl_start,
    output mtep_pkg::mtep_tbl_req_t tbl_req,
    output logic [AW-1:0]           tbl_addr,
    output logic [31:0]             tbl_wr_start,
    output logic                    out_valid,
    output mtep_pkg::mtep_result_t  result
);

    localparam int SW = ((TICK_WIDTH > 28) ? TICK_WIDTH : 28) + 1;
    localparam logic [TICK_WIDTH-1:0] TickMax = {TICK_WIDTH{1'b1}};

    mtep_pkg::mtep_phase_t ph_reg, ph_next;
    logic [7:0]            rs_reg, rs_next;
    logic [7:0]            es_reg, es_next;
    logic [TICK_WIDTH-1:0] tick_reg, tick_next;
    logic [27:0]           vlq_reg, vlq_next;
    logic [1:0]            vb_reg, vb_next;
    logic [7:0]            mt_reg, mt_next;
    logic [27:0]           skip_reg, skip_next;
    logic [6:0]            key_reg, key_next;
    logic [23:0]           pay_reg, pay_next;
    logic [2:0]            pidx_reg, pidx_next;
    logic [15:0]           sig_reg, sig_next;
    logic                  err_reg, err_next;
    logic                  out_valid_reg;
    mtep_pkg::mtep_result_t res_reg, res_c;
    logic                  emit;

    logic                  more;
    logic [27:0]           vlq_sh;
    logic [SW-1:0]         sum;
    logic                  note_off;

    assign more         = data_byte[7];
    assign out_valid    = out_valid_reg;
    assign result       = res_reg;
    assign tbl_wr_start = 32'(tick_next);

    always_comb
    begin
        // track start reloads the reset state before the byte is parsed
        ph_next   = track_start ? mtep_pkg::PH_DELTA : ph_reg;
        rs_next   = track_start ? '0 : rs_reg;
        es_next   = track_start ? '0 : es_reg;
        tick_next = track_start ? '0 : tick_reg;
        vlq_next  = track_start ? '0 : vlq_reg;
        vb_next   = track_start ? '0 : vb_reg;
        mt_next   = track_start ? '0 : mt_reg;
        skip_next = track_start ? '0 : skip_reg;
        key_next  = track_start ? '0 : key_reg;
        pay_next  = track_start ? '0 : pay_reg;
        pidx_next = track_start ? '0 : pidx_reg;
        sig_next  = track_start ? '0 : sig_reg;
        err_next  = track_start ? 1'b0 : err_reg;

        res_c      = '0;
        emit       = 1'b0;
        tbl_req    = '0;
        tbl_addr   = '0;
        vlq_sh     = {vlq_next[20:0], data_byte[6:0]};
        sum        = SW'(tick_next) + SW'(vlq_sh);
        note_off   = (es_next[7:4] == mtep_pkg::HI_NOTE_OFF) || (data_byte == 8'h00);

        if (acc)
        begin
            tbl_req.new_track = track_start;
            if (!err_next)
            begin
                unique case (ph_next)
                    mtep_pkg::PH_DELTA:
                    begin
                        if (more && vb_next == 2'd3)
                        begin
                            err_next         = 1'b1;
                            emit             = 1'b1;
                            res_c.kind       = mtep_pkg::KIND_ERROR;
                            res_c.error_code = mtep_pkg::ERR_DELTA_VLQ;
                        end
                        else if (more)
                        begin
                            vlq_next = vlq_sh;
                            vb_next  = vb_next + 2'd1;
                        end
                        else
                        begin
                            tick_next = (sum > SW'(TickMax)) ? TickMax : TICK_WIDTH'(sum);
                            vlq_next  = '0;
                            vb_next   = '0;
                            ph_next   = mtep_pkg::PH_STATUS;
                        end
                    end
                    mtep_pkg::PH_STATUS, mtep_pkg::PH_DATA1:
                    begin
                        if (ph_next == mtep_pkg::PH_STATUS && more)
                        begin
                            if (data_byte == mtep_pkg::ST_SYSEX ||
                                data_byte == mtep_pkg::ST_SYSEX_ESC)
                            begin
                                es_next  = data_byte;
                                rs_next  = '0;
                                vlq_next = '0;
                                vb_next  = '0;
                                ph_next  = mtep_pkg::PH_LEN;
                            end
                            else if (data_byte == mtep_pkg::ST_META)
                            begin
                                es_next = data_byte;
                                rs_next = '0;
                                ph_next = mtep_pkg::PH_MTYPE;
                            end
                            else if (data_byte[7:4] == mtep_pkg::HI_SYSTEM)
                            begin
                                err_next         = 1'b1;
                                emit             = 1'b1;
                                res_c.kind       = mtep_pkg::KIND_ERROR;
                                res_c.error_code = mtep_pkg::ERR_STATUS;
                            end
                            else
                            begin
                                rs_next = data_byte;
                                es_next = data_byte;
                                ph_next = mtep_pkg::PH_DATA1;
                            end
                        end
                        else if (ph_next == mtep_pkg::PH_STATUS && rs_next == 8'h00)
                        begin
                            err_next         = 1'b1;
                            emit             = 1'b1;
                            res_c.kind       = mtep_pkg::KIND_ERROR;
                            res_c.error_code = mtep_pkg::ERR_STATUS;
                        end
                        else
                        begin
                            // first data byte, possibly under running status
                            if (ph_next == mtep_pkg::PH_STATUS)
                            begin
                                es_next = rs_next;
                            end
                            if (es_next[7:4] == mtep_pkg::HI_PROG ||
                                es_next[7:4] == mtep_pkg::HI_PRESS)
                            begin
                                ph_next = mtep_pkg::PH_DELTA;
                            end
                            else
                            begin
                                key_next      = data_byte[6:0];
                                ph_next       = mtep_pkg::PH_DATA2;
                                tbl_req.rd_en = 1'b1;
                                tbl_addr      = AW'(int'(es_next[3:0]) * KEYS
                                                    + int'(data_byte[6:0]));
                            end
                        end
                    end
                    mtep_pkg::PH_DATA2:
                    begin
                        ph_next  = mtep_pkg::PH_DELTA;
                        tbl_addr = AW'(int'(es_next[3:0]) * KEYS + int'(key_next));
                        if ((es_next[7:4] == mtep_pkg::HI_NOTE_OFF ||
                             es_next[7:4] == mtep_pkg::HI_NOTE_ON) &&
                            int'(es_next[3:0]) < CHANNELS && int'(key_next) < KEYS)
                        begin
                            if (note_off)
                            begin
                                if (tbl_active)
                                begin
                                    tbl_req.wr_en     = 1'b1;
                                    tbl_req.wr_active = 1'b0;
                                    emit              = 1'b1;
                                    res_c.kind        = mtep_pkg::KIND_NOTE;
                                    res_c.channel     = es_next[3:0];
                                    res_c.key         = key_next;
                                    res_c.start_tick  = tbl_start;
                                end
                            end
                            else if (!tbl_active)
                            begin
                                tbl_req.wr_en     = 1'b1;
                                tbl_req.wr_active = 1'b1;
                            end
                        end
                    end
                    mtep_pkg::PH_MTYPE:
                    begin
                        mt_next  = data_byte;
                        vlq_next = '0;
                        vb_next  = '0;
                        ph_next  = mtep_pkg::PH_LEN;
                    end
                    mtep_pkg::PH_LEN:
                    begin
                        if (more && vb_next == 2'd3)
                        begin
                            err_next         = 1'b1;
                            emit             = 1'b1;
                            res_c.kind       = mtep_pkg::KIND_ERROR;
                            res_c.error_code = mtep_pkg::ERR_LEN_VLQ;
                        end
                        else if (more)
                        begin
                            vlq_next = vlq_sh;
                            vb_next  = vb_next + 2'd1;
                        end
                        else
                        begin
                            vlq_next  = '0;
                            vb_next   = '0;
                            pay_next  = '0;
                            pidx_next = '0;
                            if (es_next == mtep_pkg::ST_META && mt_next == mtep_pkg::META_EOT)
                            begin
                                emit    = 1'b1;
                                ph_next = mtep_pkg::PH_DELTA;
                                if (vlq_sh != 28'h0)
                                begin
                                    err_next         = 1'b1;
                                    res_c.kind       = mtep_pkg::KIND_ERROR;
                                    res_c.error_code = mtep_pkg::ERR_META_LEN;
                                end
                                else
                                begin
                                    res_c.kind = mtep_pkg::KIND_EOT;
                                end
                            end
                            else if (es_next == mtep_pkg::ST_META &&
                                     (mt_next == mtep_pkg::META_TEMPO ||
                                      mt_next == mtep_pkg::META_TSIG))
                            begin
                                if ((mt_next == mtep_pkg::META_TEMPO &&
                                     vlq_sh != mtep_pkg::LEN_TEMPO) ||
                                    (mt_next == mtep_pkg::META_TSIG &&
                                     vlq_sh != mtep_pkg::LEN_TSIG))
                                begin
                                    err_next         = 1'b1;
                                    emit             = 1'b1;
                                    res_c.kind       = mtep_pkg::KIND_ERROR;
                                    res_c.error_code = mtep_pkg::ERR_META_LEN;
                                end
                                else
                                begin
                                    ph_next = mtep_pkg::PH_PAYLOAD;
                                end
                            end
                            else
                            begin
                                skip_next = vlq_sh;
                                ph_next   = (vlq_sh != 28'h0) ? mtep_pkg::PH_SKIP
                                                              : mtep_pkg::PH_DELTA;
                            end
                        end
                    end
                    mtep_pkg::PH_SKIP:
                    begin
                        if (skip_next != 28'h0)
                        begin
                            skip_next = skip_next - 28'd1;
                        end
                        if (skip_next == 28'h0)
                        begin
                            ph_next = mtep_pkg::PH_DELTA;
                        end
                    end
                    mtep_pkg::PH_PAYLOAD:
                    begin
                        if (mt_next == mtep_pkg::META_TEMPO)
                        begin
                            pay_next  = {pay_next[15:0], data_byte};
                            pidx_next = pidx_next + 3'd1;
                            if (pidx_next == 3'd3)
                            begin
                                ph_next           = mtep_pkg::PH_DELTA;
                                pidx_next         = '0;
                                emit              = 1'b1;
                                res_c.kind        = mtep_pkg::KIND_TEMPO;
                                res_c.tempo_value = pay_next;
                            end
                        end
                        else
                        begin
                            if (pidx_next < 3'd2)
                            begin
                                sig_next = {sig_next[7:0], data_byte};
                            end
                            pidx_next = pidx_next + 3'd1;
                            if (pidx_next == 3'd4)
                            begin
                                ph_next                   = mtep_pkg::PH_DELTA;
                                pidx_next                 = '0;
                                emit                      = 1'b1;
                                res_c.kind                = mtep_pkg::KIND_TSIG;
                                res_c.sig_numerator       = sig_next[15:8];
                                res_c.sig_denominator_exp = sig_next[7:0];
                            end
                        end
                    end
                    default:
                    begin
                        ph_next = mtep_pkg::PH_DELTA;
                    end
                endcase
            end
        end
        res_c.event_tick = 32'(tick_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg        <= mtep_pkg::PH_DELTA;
            rs_reg        <= '0;
            es_reg        <= '0;
            tick_reg      <= '0;
            vlq_reg       <= '0;
            vb_reg        <= '0;
            mt_reg        <= '0;
            skip_reg      <= '0;
            key_reg       <= '0;
            pay_reg       <= '0;
            pidx_reg      <= '0;
            sig_reg       <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                ph_reg   <= ph_next;
                rs_reg   <= rs_next;
                es_reg   <= es_next;
                tick_reg <= tick_next;
                vlq_reg  <= vlq_next;
                vb_reg   <= vb_next;
                mt_reg   <= mt_next;
                skip_reg <= skip_next;
                key_reg  <= key_next;
                pay_reg  <= pay_next;
                pidx_reg <= pidx_next;
                sig_reg  <= sig_next;
                err_reg  <= err_next;
                out_valid_reg <= emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && emit)
        begin
            res_reg <= res_c;
        end
    end

endmodule

>>> rtl/core/midi_track_event_parser_top.sv
// Top level of the MIDI track event parser.
// A result is registered and shows on the output in the cycle after the byte that causes it.
// Throughput: one track byte per cycle while ready is high; at most one table access per byte.
// Reset: control state clears at once; the note table then sweeps its
//   CHANNELS*KEYS entries (2048 by default) with input ready low.
// The same sweep runs after every 256th track start, when the epoch tag wraps.
module midi_track_event_parser_top #(
    parameter int CHANNELS   = 16,
    parameter int KEYS       = 128,
    parameter int TICK_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    mtep_in_if.sink    track,
    mtep_out_if.source events
);

    // table geometry
    localparam int DEPTH = CHANNELS * KEYS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    mtep_pkg::mtep_tbl_req_t tbl_req;
    logic [AW-1:0]           tbl_addr;
    logic [31:0]             tbl_wr_start;
    logic                    tbl_active;
    logic [31:0]             tbl_start;
    logic                    tbl_busy;
    logic                    acc;
    logic                    out_valid;
    mtep_pkg::mtep_result_t  result;

    // a byte transfers when the table is not sweeping and the result slot is free or being drained
    assign track.ready = !tbl_busy && (!out_valid || events.ready);
    assign acc         = track.valid && track.ready;

    mtep_note_table #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (tbl_req),
        .addr      (tbl_addr),
        .wr_start  (tbl_wr_start),
        .rd_active (tbl_active),
        .rd_start  (tbl_start),
        .busy      (tbl_busy)
    );

    mtep_parser #(
        .CHANNELS   (CHANNELS),
        .KEYS       (KEYS),
        .TICK_WIDTH (TICK_WIDTH),
        .AW         (AW)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .acc          (acc),
        .data_byte    (track.data_byte),
        .track_start  (track.track_start),
        .out_ready    (events.ready),
        .tbl_active   (tbl_active),
        .tbl_start    (tbl_start),
        .tbl_req      (tbl_req),
        .tbl_addr     (tbl_addr),
        .tbl_wr_start (tbl_wr_start),
        .out_valid    (out_valid),
        .result       (result)
    );

    assign events.valid               = out_valid;
    assign events.kind                = result.kind;
    assign events.channel             = result.channel;
    assign events.key                 = result.key;
    assign events.start_tick          = result.start_tick;
    assign events.event_tick          = result.event_tick;
    assign events.tempo_value         = result.tempo_value;
    assign events.sig_numerator       = result.sig_numerator;
    assign events.sig_denominator_exp = result.sig_denominator_exp;
    assign events.error_code          = result.error_code;

endmodule

>>> rtl/core/mtep_checker.sv
// Port-level checks for the MIDI track event parser, bound to the top level.
module mtep_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  kind,
    input logic [3:0]  channel,
    input logic [6:0]  key,
    input logic [31:0] start_tick,
    input logic [23:0] tempo_value,
    input logic [1:0]  error_code
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(channel)
        && $stable(key) && $stable(start_tick) && $stable(tempo_value)
        && $stable(error_code))
        else $error("result changed while stalled");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind <= mtep_pkg::KIND_ERROR)
        else $error("result kind out of range");

    a_note_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != mtep_pkg::KIND_NOTE
        |-> channel == '0 && key == '0 && start_tick == '0)
        else $error("note fields set on a non-note event");

    a_tempo_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != mtep_pkg::KIND_TEMPO && kind != mtep_pkg::KIND_ERROR
        |-> tempo_value == '0 && error_code == '0)
        else $error("tempo or error field set on wrong event kind");

endmodule

bind midi_track_event_parser_top mtep_checker u_mtep_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (events.valid),
    .out_ready   (events.ready),
    .kind        (events.kind),
    .channel     (events.channel),
    .key         (events.key),
    .start_tick  (events.start_tick),
    .tempo_value (events.tempo_value),
    .error_code  (events.error_code)
);
